@@ src/dds_pkg.sv @@
// Shared types, constants and saturating helpers for the differential-drive
// state derivative block. Every other file in src depends on this package.
package dds_pkg;

	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned HEAD_WIDTH = 19;
	localparam int unsigned CFG_WIDTH  = 31;
	localparam int unsigned IDX_WIDTH  = 3;

	localparam logic [IDX_WIDTH-1:0] REG_DECAY   = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_V2A     = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_RADIUS  = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_GEAR    = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_LEVER   = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_SPACING = 3'd5;

	localparam logic [CFG_WIDTH-1:0] CFG_MAX = {CFG_WIDTH{1'b1}};

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	localparam word_t SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [HEAD_WIDTH-1:0] heading;
		word_t                        speed;
		word_t                        turn_rate;
		word_t                        drive_sum;
		word_t                        drive_diff;
		word_t                        noise_sum;
		word_t                        noise_diff;
	} item_t;

	typedef struct packed {
		word_t x_rate;
		word_t y_rate;
		word_t heading_rate;
		word_t speed_rate;
		word_t turn_accel;
	} result_t;

	// Raw and derived coefficients handed from the register file to the datapath.
	typedef struct packed {
		logic [CFG_WIDTH-1:0] decay;
		logic [CFG_WIDTH-1:0] lever_len;
		logic [CFG_WIDTH-1:0] gain_half;
		logic [CFG_WIDTH-1:0] ratio;
	} cfg_t;

	function automatic logic [DATA_WIDTH-1:0] mag_of(input word_t v);
		return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// Signed result from a truncated magnitude, clipped to the word range.
	function automatic word_t sat_mag(input logic [63:0] mag, input logic neg);
		word_t res;
		if (neg) begin
			if (mag >= 64'(SAT_MAX) + 64'd1) res = SAT_MIN;
			else res = -$signed(mag[DATA_WIDTH-1:0]);
		end else begin
			if (mag > 64'(SAT_MAX)) res = SAT_MAX;
			else res = $signed(mag[DATA_WIDTH-1:0]);
		end
		return res;
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
		return s[DATA_WIDTH-1:0];
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
		return s[DATA_WIDTH-1:0];
	endfunction

endpackage

@@ src/dds_cfg.sv @@
// Configuration registers and the sequencer that derives the drive gain and
// the gain over wheel spacing after each write. Depends on dds_pkg.
module dds_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [dds_pkg::IDX_WIDTH-1:0]   cfg_index,
	input  logic [dds_pkg::DATA_WIDTH-1:0]  cfg_data,
	output dds_pkg::cfg_t                   coef,
	output logic                            recompute
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_SAT1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_SAT2 = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	localparam int unsigned CW    = dds_pkg::CFG_WIDTH;
	localparam int unsigned FB    = dds_pkg::FRAC_BITS;
	localparam int unsigned NUM_W = CW + FB;
	localparam logic [5:0]  LAST_STEP = 6'(NUM_W - 1);
	localparam logic [CW-1:0] ONE_FIX = CW'(1) << FB;

	logic [2:0]        state_q;
	logic [CW-1:0]     decay_q, v2a_q, radius_q, gear_q, lever_q, spacing_q;
	logic [2*CW-1:0]   prod_q;
	logic [CW-1:0]     part_q;
	logic [NUM_W-1:0]  num_q, quot_q;
	logic [CW-1:0]     rem_q;
	logic [5:0]        step_q;
	logic [CW-1:0]     gain_half_q, ratio_q;

	logic [2*CW-FB-1:0] shifted;
	logic [CW-1:0]      prod_sat;
	logic [CW:0]        trial;
	logic               take;

	assign shifted  = prod_q[2*CW-1:FB];
	assign prod_sat = (shifted > (2*CW-FB)'(dds_pkg::SAT_MAX)) ? dds_pkg::CFG_MAX
	                  : shifted[CW-1:0];
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign take     = trial >= {1'b0, spacing_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			decay_q     <= '0;
			v2a_q       <= '0;
			radius_q    <= '0;
			gear_q      <= ONE_FIX;
			lever_q     <= '0;
			spacing_q   <= ONE_FIX;
			prod_q      <= '0;
			part_q      <= '0;
			num_q       <= '0;
			quot_q      <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			gain_half_q <= '0;
			ratio_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					dds_pkg::REG_DECAY:   decay_q   <= cfg_data[CW-1:0];
					dds_pkg::REG_V2A:     v2a_q     <= cfg_data[CW-1:0];
					dds_pkg::REG_RADIUS:  radius_q  <= cfg_data[CW-1:0];
					dds_pkg::REG_GEAR:    gear_q    <= cfg_data[CW-1:0];
					dds_pkg::REG_LEVER:   lever_q   <= cfg_data[CW-1:0];
					dds_pkg::REG_SPACING: spacing_q <= cfg_data[CW-1:0];
					default: ;
				endcase
			end
			// A new write restarts the derivation from the first product.
			priority if (cfg_valid) begin
				state_q <= ST_MUL1;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_MUL1: begin
						prod_q  <= v2a_q * gear_q;
						state_q <= ST_SAT1;
					end
					ST_SAT1: begin
						part_q  <= prod_sat;
						state_q <= ST_MUL2;
					end
					ST_MUL2: begin
						prod_q  <= part_q * radius_q;
						state_q <= ST_SAT2;
					end
					ST_SAT2: begin
						part_q  <= prod_sat;
						num_q   <= {prod_sat, FB'(0)};
						rem_q   <= '0;
						quot_q  <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
					ST_DIV: begin
						rem_q  <= take ? CW'(trial - {1'b0, spacing_q}) : trial[CW-1:0];
						quot_q <= {quot_q[NUM_W-2:0], take};
						num_q  <= {num_q[NUM_W-2:0], 1'b0};
						step_q <= step_q + 6'd1;
						if (step_q == LAST_STEP) state_q <= ST_FIN;
					end
					ST_FIN: begin
						gain_half_q <= part_q >> 1;
						if (spacing_q == '0)
							ratio_q <= (part_q == '0) ? '0 : dds_pkg::CFG_MAX;
						else if (quot_q > NUM_W'(dds_pkg::CFG_MAX))
							ratio_q <= dds_pkg::CFG_MAX;
						else
							ratio_q <= quot_q[CW-1:0];
						state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign coef.decay     = decay_q;
	assign coef.lever_len = lever_q;
	assign coef.gain_half = gain_half_q;
	assign coef.ratio     = ratio_q;
	assign recompute      = (state_q != ST_IDLE);

endmodule

@@ src/dds_trig.sv @@
// Pipelined sine and cosine of the heading in Q2.30: range folding, then
// Horner polynomials with constant divisions by reciprocal. Depends on dds_pkg.
module dds_trig (
	input  logic                                   clk,
	input  logic signed [dds_pkg::HEAD_WIDTH-1:0]  heading,
	output dds_pkg::word_t                         sin_val,
	output dds_pkg::word_t                         cos_val
);

	localparam int unsigned HW = dds_pkg::HEAD_WIDTH;
	localparam int unsigned HEAD_SHIFT = 30 - dds_pkg::FRAC_BITS;
	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam int unsigned STEPS = 4;
	localparam int unsigned LINE  = 3 * STEPS;

	// Lane 0 is sine, lane 1 cosine. Each division is by reciprocal with
	// one correction step.
	localparam logic [31:0] DIV_C [2][STEPS] = '{
		'{32'd72, 32'd42, 32'd20, 32'd6},
		'{32'd90, 32'd56, 32'd30, 32'd12}};
	localparam int unsigned DIV_K [2][STEPS] = '{
		'{38, 37, 36, 34},
		'{38, 37, 36, 35}};
	localparam logic [31:0] DIV_M [2][STEPS] = '{
		'{32'((64'd1 << 38) / 64'd72), 32'((64'd1 << 37) / 64'd42),
		  32'((64'd1 << 36) / 64'd20), 32'((64'd1 << 34) / 64'd6)},
		'{32'((64'd1 << 38) / 64'd90), 32'((64'd1 << 37) / 64'd56),
		  32'((64'd1 << 36) / 64'd30), 32'((64'd1 << 35) / 64'd12)}};

	typedef struct packed {
		logic [30:0] a;
		logic [31:0] x2;
		logic        ns;
		logic        nc;
	} line_t;

	logic [HW-1:0] mag;
	logic [32:0]   a0;
	logic [31:0]   a_s2;
	logic          ns_s2;
	logic [30:0]   a_s3;
	logic          ns_s3, nc_s3;
	logic [61:0]   sq;
	line_t         line_s [LINE+1];

	logic [63:0]   pa_s [2][STEPS];
	logic [31:0]   pv_s [2][STEPS];
	logic [63:0]   pm_s [2][STEPS];
	logic [30:0]   t_s  [2][STEPS+1];
	logic [31:0]   q_c  [2][STEPS];

	logic [61:0]   fs_s17;
	logic [62:0]   fc_s17;
	logic          ns_s17, nc_s17;
	logic [31:0]   sv;
	logic signed [33:0] cv;

	assign mag = heading[HW-1] ? HW'(-heading) : HW'(heading);
	assign a0  = 33'(mag) << HEAD_SHIFT;
	assign sq  = a_s3 * a_s3;

	always_ff @(posedge clk) begin
		a_s2  <= (a0 > PI_Q30) ? 32'(TWO_PI_Q30 - a0) : a0[31:0];
		ns_s2 <= heading[HW-1] ^ (a0 > PI_Q30);
		a_s3  <= (33'(a_s2) > HALF_PI_Q30) ? 31'(PI_Q30 - 33'(a_s2)) : a_s2[30:0];
		nc_s3 <= (33'(a_s2) > HALF_PI_Q30);
		ns_s3 <= ns_s2;
		line_s[0] <= '{a: a_s3, x2: sq[61:30], ns: ns_s3, nc: nc_s3};
		for (int i = 1; i <= LINE; i++) line_s[i] <= line_s[i-1];
	end

	always_comb begin
		logic [31:0] q0;
		logic [32:0] r;
		for (int l = 0; l < 2; l++) begin
			for (int j = 0; j < STEPS; j++) begin
				q0 = 32'(pm_s[l][j] >> DIV_K[l][j]);
				r  = {1'b0, pv_s[l][j]} - 33'(q0 * DIV_C[l][j]);
				q_c[l][j] = (r >= 33'(DIV_C[l][j])) ? q0 + 32'd1 : q0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			// The first Horner step always starts from one.
			t_s[l][0] <= ONE_Q30;
			for (int j = 0; j < STEPS; j++) begin
				pa_s[l][j]  <= line_s[3*j].x2 * t_s[l][j];
				pv_s[l][j]  <= pa_s[l][j][61:30];
				pm_s[l][j]  <= pa_s[l][j][61:30] * DIV_M[l][j];
				t_s[l][j+1] <= 31'(ONE_Q30 - q_c[l][j]);
			end
		end
		fs_s17 <= line_s[LINE].a * t_s[0][STEPS];
		fc_s17 <= line_s[LINE].x2 * t_s[1][STEPS];
		ns_s17 <= line_s[LINE].ns;
		nc_s17 <= line_s[LINE].nc;
	end

	assign sv = fs_s17[61:30];
	assign cv = 34'(ONE_Q30) - 34'(fc_s17[62:31]);

	always_ff @(posedge clk) begin
		sin_val <= ns_s17 ? -$signed(sv) : $signed(sv);
		cos_val <= nc_s17 ? 32'(-cv) : 32'(cv);
	end

endmodule

@@ src/dds_lin.sv @@
// Lever arm term and the speed and turn-rate derivatives, four register
// stages of products, saturation and saturated sums. Depends on dds_pkg.
module dds_lin (
	input  logic           clk,
	input  dds_pkg::item_t item,
	input  dds_pkg::cfg_t  coef,
	output dds_pkg::word_t lever,
	output dds_pkg::word_t speed_rate,
	output dds_pkg::word_t turn_accel
);

	localparam int unsigned FB = dds_pkg::FRAC_BITS;

	dds_pkg::word_t cmd1_s1, cmd2_s1;
	logic [62:0]    pds_s1, pdt_s1, plv_s1;
	logic           nsp_s1, ntr_s1;
	dds_pkg::word_t dsp_s2, dtr_s2;
	logic [62:0]    pg1_s2, pg2_s2;
	logic           n1_s2, n2_s2;
	dds_pkg::word_t g1_s3, g2_s3, dsp_s3, dtr_s3;

	always_ff @(posedge clk) begin
		cmd1_s1 <= dds_pkg::sat_add(item.drive_sum, item.noise_sum);
		cmd2_s1 <= dds_pkg::sat_add(item.drive_diff, item.noise_diff);
		pds_s1  <= coef.decay * dds_pkg::mag_of(item.speed);
		pdt_s1  <= coef.decay * dds_pkg::mag_of(item.turn_rate);
		plv_s1  <= coef.lever_len * dds_pkg::mag_of(item.turn_rate);
		nsp_s1  <= item.speed[dds_pkg::DATA_WIDTH-1];
		ntr_s1  <= item.turn_rate[dds_pkg::DATA_WIDTH-1];

		dsp_s2  <= dds_pkg::sat_mag(64'(pds_s1 >> FB), nsp_s1);
		dtr_s2  <= dds_pkg::sat_mag(64'(pdt_s1 >> FB), ntr_s1);
		lever   <= dds_pkg::sat_mag(64'(plv_s1 >> FB), ntr_s1);
		pg1_s2  <= coef.gain_half * dds_pkg::mag_of(cmd1_s1);
		pg2_s2  <= coef.ratio * dds_pkg::mag_of(cmd2_s1);
		n1_s2   <= cmd1_s1[dds_pkg::DATA_WIDTH-1];
		n2_s2   <= cmd2_s1[dds_pkg::DATA_WIDTH-1];

		g1_s3   <= dds_pkg::sat_mag(64'(pg1_s2 >> FB), n1_s2);
		g2_s3   <= dds_pkg::sat_mag(64'(pg2_s2 >> FB), n2_s2);
		dsp_s3  <= dsp_s2;
		dtr_s3  <= dtr_s2;

		speed_rate <= dds_pkg::sat_sub(g1_s3, dsp_s3);
		turn_accel <= dds_pkg::sat_sub(g2_s3, dtr_s3);
	end

endmodule

@@ src/dds_rot.sv @@
// Rotation of speed and lever-arm velocity by heading into x and y rates,
// three register stages. Depends on dds_pkg.
module dds_rot (
	input  logic           clk,
	input  dds_pkg::word_t speed,
	input  dds_pkg::word_t lever,
	input  dds_pkg::word_t sin_val,
	input  dds_pkg::word_t cos_val,
	output dds_pkg::word_t x_rate,
	output dds_pkg::word_t y_rate
);

	localparam int unsigned MSB = dds_pkg::DATA_WIDTH - 1;

	logic [63:0]    psc_s1, pls_s1, pss_s1, plc_s1;
	logic           nsc_s1, nls_s1, nss_s1, nlc_s1;
	dds_pkg::word_t sc_s2, ls_s2, ss_s2, lc_s2;

	always_ff @(posedge clk) begin
		psc_s1 <= dds_pkg::mag_of(speed) * dds_pkg::mag_of(cos_val);
		pls_s1 <= dds_pkg::mag_of(lever) * dds_pkg::mag_of(sin_val);
		pss_s1 <= dds_pkg::mag_of(speed) * dds_pkg::mag_of(sin_val);
		plc_s1 <= dds_pkg::mag_of(lever) * dds_pkg::mag_of(cos_val);
		nsc_s1 <= speed[MSB] ^ cos_val[MSB];
		nls_s1 <= lever[MSB] ^ sin_val[MSB];
		nss_s1 <= speed[MSB] ^ sin_val[MSB];
		nlc_s1 <= lever[MSB] ^ cos_val[MSB];

		sc_s2 <= dds_pkg::sat_mag(psc_s1 >> 30, nsc_s1);
		ls_s2 <= dds_pkg::sat_mag(pls_s1 >> 30, nls_s1);
		ss_s2 <= dds_pkg::sat_mag(pss_s1 >> 30, nss_s1);
		lc_s2 <= dds_pkg::sat_mag(plc_s1 >> 30, nlc_s1);

		x_rate <= dds_pkg::sat_sub(sc_s2, ls_s2);
		y_rate <= dds_pkg::sat_add(ss_s2, lc_s2);
	end

endmodule

@@ src/diff_drive_state_derivative.sv @@
// Differential-drive state derivative. An accepted word and its valid bit
// move down the vld_s/item_s register line; done and the result are valid
// when that bit reaches the last stage. One word per cycle is sustained
// while busy is low, as the sine/cosine and multipliers are fully pipelined.
// After a configuration write, busy stays high while the gain and the gain
// over wheel spacing are rederived by a bit-serial divider.
// Reset clears all valid bits and loads the register reset values.
module diff_drive_state_derivative (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  dds_pkg::item_t                 item,
	output logic                           done,
	output dds_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dds_pkg::IDX_WIDTH-1:0]  cfg_index,
	input  logic [dds_pkg::DATA_WIDTH-1:0] cfg_data
);

	localparam int unsigned LAST    = 21;
	localparam int unsigned LIN_TAP = 16;
	localparam int unsigned ROT_TAP = 18;

	logic             recompute;
	dds_pkg::cfg_t    coef;
	logic             vld_s  [1:LAST];
	dds_pkg::item_t   item_s [1:LAST];
	dds_pkg::word_t   sin_s18, cos_s18, lever_s18;
	dds_pkg::word_t   sr_s20, ta_s20, sr_s21, ta_s21;
	dds_pkg::word_t   x_s21, y_s21;

	// A word is never taken in the same cycle as a register write.
	assign busy      = recompute | cfg_valid;
	assign cfg_ready = 1'b1;

	dds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef),
		.recompute (recompute)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= start & ~busy;
			for (int i = 2; i <= LAST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		item_s[1] <= item;
		for (int i = 2; i <= LAST; i++) item_s[i] <= item_s[i-1];
		sr_s21 <= sr_s20;
		ta_s21 <= ta_s20;
	end

	dds_trig u_trig (
		.clk     (clk),
		.heading (item_s[1].heading),
		.sin_val (sin_s18),
		.cos_val (cos_s18)
	);

	dds_lin u_lin (
		.clk        (clk),
		.item       (item_s[LIN_TAP]),
		.coef       (coef),
		.lever      (lever_s18),
		.speed_rate (sr_s20),
		.turn_accel (ta_s20)
	);

	dds_rot u_rot (
		.clk     (clk),
		.speed   (item_s[ROT_TAP].speed),
		.lever   (lever_s18),
		.sin_val (sin_s18),
		.cos_val (cos_s18),
		.x_rate  (x_s21),
		.y_rate  (y_s21)
	);

	assign done                = vld_s[LAST];
	assign result.x_rate       = x_s21;
	assign result.y_rate       = y_s21;
	assign result.heading_rate = item_s[LAST].turn_rate;
	assign result.speed_rate   = sr_s21;
	assign result.turn_accel   = ta_s21;

endmodule
